FILE: sv/rvd_pkg.sv
// ----------------------------------------------------------------------------
// rvd_pkg
// Shared constants and types for the RV32I instruction decoder: base opcodes,
// mnemonic codes and the bundle of decoded fields.
// ----------------------------------------------------------------------------
package rvd_pkg;

  // Base opcodes (instruction bits 6..0).
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;

  // The one SYSTEM word that is matched as a whole.
  localparam logic [31:0] WORD_MRET = 32'h3020_0073;

  // funct7 values of the OP group.
  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // funct3 values.
  localparam logic [2:0] F3_0 = 3'd0;
  localparam logic [2:0] F3_1 = 3'd1;
  localparam logic [2:0] F3_2 = 3'd2;
  localparam logic [2:0] F3_3 = 3'd3;
  localparam logic [2:0] F3_4 = 3'd4;
  localparam logic [2:0] F3_5 = 3'd5;
  localparam logic [2:0] F3_6 = 3'd6;
  localparam logic [2:0] F3_7 = 3'd7;

  localparam int unsigned MN_W = 6;

  // Dense mnemonic codes.
  localparam logic [MN_W-1:0] MN_UNKNOWN = 6'd0;
  localparam logic [MN_W-1:0] MN_ADD     = 6'd1;
  localparam logic [MN_W-1:0] MN_SLL     = 6'd2;
  localparam logic [MN_W-1:0] MN_SLT     = 6'd3;
  localparam logic [MN_W-1:0] MN_SLTU    = 6'd4;
  localparam logic [MN_W-1:0] MN_XOR     = 6'd5;
  localparam logic [MN_W-1:0] MN_SRL     = 6'd6;
  localparam logic [MN_W-1:0] MN_OR      = 6'd7;
  localparam logic [MN_W-1:0] MN_AND     = 6'd8;
  localparam logic [MN_W-1:0] MN_SUB     = 6'd9;
  localparam logic [MN_W-1:0] MN_SRA     = 6'd10;
  localparam logic [MN_W-1:0] MN_ADDI    = 6'd11;
  localparam logic [MN_W-1:0] MN_SLLI    = 6'd12;
  localparam logic [MN_W-1:0] MN_SLTI    = 6'd13;
  localparam logic [MN_W-1:0] MN_SLTIU   = 6'd14;
  localparam logic [MN_W-1:0] MN_XORI    = 6'd15;
  localparam logic [MN_W-1:0] MN_SRLI    = 6'd16;
  localparam logic [MN_W-1:0] MN_ORI     = 6'd17;
  localparam logic [MN_W-1:0] MN_ANDI    = 6'd18;
  localparam logic [MN_W-1:0] MN_SRAI    = 6'd19;
  localparam logic [MN_W-1:0] MN_LB      = 6'd20;
  localparam logic [MN_W-1:0] MN_LH      = 6'd21;
  localparam logic [MN_W-1:0] MN_LW      = 6'd22;
  localparam logic [MN_W-1:0] MN_LBU     = 6'd23;
  localparam logic [MN_W-1:0] MN_LHU     = 6'd24;
  localparam logic [MN_W-1:0] MN_SB      = 6'd25;
  localparam logic [MN_W-1:0] MN_SH      = 6'd26;
  localparam logic [MN_W-1:0] MN_SW      = 6'd27;
  localparam logic [MN_W-1:0] MN_BEQ     = 6'd28;
  localparam logic [MN_W-1:0] MN_BNE     = 6'd29;
  localparam logic [MN_W-1:0] MN_BLT     = 6'd30;
  localparam logic [MN_W-1:0] MN_BGE     = 6'd31;
  localparam logic [MN_W-1:0] MN_BLTU    = 6'd32;
  localparam logic [MN_W-1:0] MN_BGEU    = 6'd33;
  localparam logic [MN_W-1:0] MN_JALR    = 6'd34;
  localparam logic [MN_W-1:0] MN_MRET    = 6'd35;
  localparam logic [MN_W-1:0] MN_CSRRW   = 6'd36;
  localparam logic [MN_W-1:0] MN_EBREAK  = 6'd37;
  localparam logic [MN_W-1:0] MN_ECALL   = 6'd38;
  localparam logic [MN_W-1:0] MN_LUI     = 6'd39;
  localparam logic [MN_W-1:0] MN_AUIPC   = 6'd40;
  localparam logic [MN_W-1:0] MN_JAL     = 6'd41;
  localparam logic [MN_W-1:0] MN_J       = 6'd42;

  // Stream widths: input is instr then pc, output is padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_FIELD_W = 85;
  localparam int unsigned OUT_TDATA_W = 88;

  // Decoded fields of one instruction.
  typedef struct packed {
    logic [MN_W-1:0]    mnemonic;
    logic [4:0]         dest_reg;
    logic [4:0]         src_reg1;
    logic [4:0]         src_reg2;
    logic signed [31:0] immediate;
    logic [31:0]        target;
  } dec_result_t;

endpackage

FILE: sv/rv32i_instruction_decoder_top.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder_top
// Streaming RV32I decoder: an input register, the decode logic and a result
// register, one instruction word per clock while m_axis takes results.
//
//   channel  dir  fields (tdata, lowest bit up)
//   s_axis   in   instr[31:0], pc[63:32]
//   m_axis   out  mnemonic[5:0], dest_reg[10:6], src_reg1[15:11],
//                 src_reg2[20:16], immediate[52:21], target[84:53], zero[87:85]
//
// One item per clock sustained while m_axis takes results; an accepted item
// passes the input register, then the result register, before it is offered.
// Reset empties both stages; no item is held across reset.
// A stall on m_axis holds the result stage, and an empty input stage can still
// take one item; s_axis_tready drops only when both stages hold an item and the
// result is not taken.
// ----------------------------------------------------------------------------
module rv32i_instruction_decoder_top
  import rvd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // instr[31:0], pc[63:32]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata    // mnemonic, dest_reg, src_reg1,
                                                 // src_reg2, immediate, target, pad
);

  logic        in_valid_q;
  logic [31:0] instr_q;
  logic [31:0] pc_q;
  logic        out_valid_q;
  dec_result_t res_q;
  dec_result_t res_d;
  logic        out_load;
  logic        in_load;

  // Stage advance: the result register frees up when it is empty or taken.
  assign out_load      = !out_valid_q || m_axis_tready;
  assign in_load       = !in_valid_q || out_load;
  assign s_axis_tready = in_load;

  // Input stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk_i) begin
    if (in_load && s_axis_tvalid) begin
      instr_q <= s_axis_tdata[31:0];
      pc_q    <= s_axis_tdata[63:32];
    end
  end

  rvd_decode u_decode (
    .instr_i  (instr_q),
    .pc_i     (pc_q),
    .result_o (res_d)
  );

  // Result stage valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result stage payload.
  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      res_q <= res_d;
    end
  end

  // Pack the result, first field lowest.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}},
                          res_q.target, res_q.immediate, res_q.src_reg2,
                          res_q.src_reg1, res_q.dest_reg, res_q.mnemonic};

endmodule

FILE: sv/rvd_decode.sv
// ----------------------------------------------------------------------------
// rvd_decode
// Combinational decode of one RV32I word: mnemonic, register fields,
// format immediate and pc-relative target for branches and JAL.
// ----------------------------------------------------------------------------
module rvd_decode
  import rvd_pkg::*;
(
  input  logic [31:0] instr_i,
  input  logic [31:0] pc_i,
  output dec_result_t result_o
);

  logic [6:0]      opc;
  logic [2:0]      f3;
  logic [6:0]      f7;
  logic [31:0]     imm_i;
  logic [31:0]     imm_s;
  logic [31:0]     imm_b;
  logic [31:0]     imm_j;
  logic [31:0]     imm_u;
  logic [MN_W-1:0] code;
  logic [31:0]     imm;
  logic            use_b;
  logic            use_j;
  logic [31:0]     offset;
  logic [31:0]     tgt_sum;

  assign opc = instr_i[6:0];
  assign f3  = instr_i[14:12];
  assign f7  = instr_i[31:25];

  // Immediates of every format, sign extended where the format asks for it.
  assign imm_i = {{20{instr_i[31]}}, instr_i[31:20]};
  assign imm_s = {{20{instr_i[31]}}, instr_i[31:25], instr_i[11:7]};
  assign imm_b = {{19{instr_i[31]}}, instr_i[31], instr_i[7], instr_i[30:25],
                  instr_i[11:8], 1'b0};
  assign imm_j = {{11{instr_i[31]}}, instr_i[31], instr_i[19:12], instr_i[20],
                  instr_i[30:21], 1'b0};
  assign imm_u = {12'd0, instr_i[31:12]};

  // Mnemonic and immediate selection by opcode.
  always_comb begin
    code  = MN_UNKNOWN;
    imm   = 32'd0;
    use_b = 1'b0;
    use_j = 1'b0;
    case (opc)
      OPC_OP: begin
        if (f7 == F7_ALT) begin
          if (f3 == F3_0) code = MN_SUB;
          else if (f3 == F3_5) code = MN_SRA;
        end else if (f7 == F7_BASE) begin
          case (f3)
            F3_0:    code = MN_ADD;
            F3_1:    code = MN_SLL;
            F3_2:    code = MN_SLT;
            F3_3:    code = MN_SLTU;
            F3_4:    code = MN_XOR;
            F3_5:    code = MN_SRL;
            F3_6:    code = MN_OR;
            default: code = MN_AND;
          endcase
        end
      end
      OPC_OPIMM: begin
        imm = imm_i;
        // Any upper bit set on a right shift picks the arithmetic form.
        if (f3 == F3_5 && f7 != 7'd0) begin
          code = MN_SRAI;
          imm  = {27'd0, imm_i[4:0]};
        end else begin
          case (f3)
            F3_0:    code = MN_ADDI;
            F3_1:    code = MN_SLLI;
            F3_2:    code = MN_SLTI;
            F3_3:    code = MN_SLTIU;
            F3_4:    code = MN_XORI;
            F3_5:    code = MN_SRLI;
            F3_6:    code = MN_ORI;
            default: code = MN_ANDI;
          endcase
        end
      end
      OPC_LOAD: begin
        imm = imm_i;
        case (f3)
          F3_0:    code = MN_LB;
          F3_1:    code = MN_LH;
          F3_2:    code = MN_LW;
          F3_4:    code = MN_LBU;
          F3_5:    code = MN_LHU;
          default: code = MN_UNKNOWN;
        endcase
      end
      OPC_STORE: begin
        imm = imm_s;
        case (f3)
          F3_0:    code = MN_SB;
          F3_1:    code = MN_SH;
          F3_2:    code = MN_SW;
          default: code = MN_UNKNOWN;
        endcase
      end
      OPC_BRANCH: begin
        imm   = imm_b;
        use_b = 1'b1;
        case (f3)
          F3_0:    code = MN_BEQ;
          F3_1:    code = MN_BNE;
          F3_4:    code = MN_BLT;
          F3_5:    code = MN_BGE;
          F3_6:    code = MN_BLTU;
          F3_7:    code = MN_BGEU;
          default: code = MN_UNKNOWN;
        endcase
      end
      OPC_JALR: begin
        code = MN_JALR;
        imm  = imm_i;
      end
      OPC_SYSTEM: begin
        imm = imm_i;
        if (instr_i == WORD_MRET) begin
          code = MN_MRET;
        end else if (f3 == F3_1) begin
          code = MN_CSRRW;
          imm  = {20'd0, instr_i[31:20]};
        end else if (instr_i[31:20] != 12'd0) begin
          code = MN_EBREAK;
        end else begin
          code = MN_ECALL;
        end
      end
      OPC_LUI: begin
        code = MN_LUI;
        imm  = imm_u;
      end
      OPC_AUIPC: begin
        code = MN_AUIPC;
        imm  = imm_u;
      end
      OPC_JAL: begin
        imm   = imm_j;
        use_j = 1'b1;
        code  = (instr_i[11:7] != 5'd0) ? MN_JAL : MN_J;
      end
      default: begin
        code = MN_UNKNOWN;
      end
    endcase
  end

  // One shared adder serves branch and jump targets.
  assign offset  = use_j ? imm_j : imm_b;
  assign tgt_sum = pc_i + offset;

  // An unknown word reports zero immediate and zero target.
  always_comb begin
    result_o.mnemonic  = code;
    result_o.dest_reg  = instr_i[11:7];
    result_o.src_reg1  = instr_i[19:15];
    result_o.src_reg2  = instr_i[24:20];
    result_o.immediate = (code == MN_UNKNOWN) ? 32'sd0 : $signed(imm);
    result_o.target    = ((use_b || use_j) && code != MN_UNKNOWN) ? tgt_sum : 32'd0;
  end

endmodule

FILE: sv/rvd_checker.sv
// ----------------------------------------------------------------------------
// rvd_checker
// Port-level checks on the decoder's result stream, bound to the top level.
// ----------------------------------------------------------------------------
module rvd_checker
  import rvd_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic [MN_W-1:0] mn;
  logic [31:0]     tgt;

  assign mn  = m_axis_tdata[5:0];
  assign tgt = m_axis_tdata[84:53];

  // No result is offered while reset is held.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // A stalled result stays offered and unchanged.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // An unknown word carries zero immediate and zero target, and padding is zero.
  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && mn == MN_UNKNOWN |-> m_axis_tdata[87:21] == '0)
    else $error("unknown word with nonzero fields");

  // Mnemonic codes stay within the defined set.
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> mn <= MN_J)
    else $error("mnemonic code out of range");

  // Only branches and jumps carry a target.
  a_target_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && tgt != 32'd0 |->
      (mn >= MN_BEQ && mn <= MN_BGEU) || mn == MN_JAL || mn == MN_J)
    else $error("target on a non-branch item");

endmodule

bind rv32i_instruction_decoder_top rvd_checker u_rvd_checker (.*);
